FILE: rtl/cdoc_pkg.sv
// Shared types and constants of the 3x3 convolution unit.
// Depends on nothing; the front, back, top level and checker use it.
package cdoc_pkg;

   // Fixed field widths.
   localparam int PIX_W     = 8;
   localparam int COEF_W    = 16;
   localparam int ROW_OUT_W = 12;
   localparam int COL_OUT_W = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 48;

   // A weighted sum of nine 8-bit pixels by 16-bit coefficients fits in 28 bits.
   localparam int SUM_W = 28;

   // Default sizes of the line stores and the row counter.
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Entries of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_TOP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_MID     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_BOTTOM  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVISOR      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET       = 3'd6;

   // Reset values of the registers.
   localparam logic [10:0] RST_FRAME_WIDTH  = 11'd640;
   localparam logic [12:0] RST_FRAME_HEIGHT = 13'd480;
   localparam logic [CSR_DAT_W-1:0] RST_COEF_TOP = 48'd1;
   localparam logic [COEF_W-1:0] RST_DIVISOR = 16'd1;

   // Largest clamped pixel value.
   localparam int PIX_MAX = 255;

   // Register values that the back end uses.
   typedef struct packed {
      logic [CSR_DAT_W-1:0] coef_top;
      logic [CSR_DAT_W-1:0] coef_mid;
      logic [CSR_DAT_W-1:0] coef_bottom;
      logic [COEF_W-1:0]    divisor;
      logic [COEF_W-1:0]    offset;
   } cfg_type;

   // One window of work: three rows by three columns, window[row][col].
   typedef struct packed {
      logic [2:0][2:0][PIX_W-1:0] win;
      logic [ROW_OUT_W-1:0]       row_base;
      logic [COL_OUT_W-1:0]       col_base;
      logic                       last_r;
      logic                       last_c;
   } job_type;

endpackage

FILE: rtl/cdoc_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module cdoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read; a read at the written address returns the old data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cdoc_fifo.sv
// Small flip-flop queue that carries windows from the front to the back.
// Depends on nothing.
module cdoc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full     = (count_ff == NW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/cdoc_front.sv
// Front end: takes pixels, keeps the line stores and the window columns,
// and queues one window for each pixel that completes outputs. Uses cdoc_pkg.
module cdoc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cdoc_pkg::PIX_W-1:0]    req_pixel_in,
   input  logic                          size_wr,
   input  logic [$clog2(MAX_WIDTH)-1:0]  col_last,
   input  logic [$clog2(MAX_HEIGHT)-1:0] row_last,
   input  logic                          queue_full,
   output logic                          push,
   output cdoc_pkg::job_type             job
);

   import cdoc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   typedef enum logic {F_READ, F_TAKE} state_type;

   state_type            state_ff;
   logic [CW-1:0]        col_ff;
   logic [RW-1:0]        row_ff;
   logic [5:0][PIX_W-1:0] wc_ff;
   logic [PIX_W-1:0]     older_rd, newer_rd;
   logic [2:0][PIX_W-1:0] cur;
   logic                 accept;
   logic                 last_c, last_r;

   // Line stores, both read at the column of the next pixel.
   cdoc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (newer_rd),
      .rd_addr (col_ff),
      .rd_data (older_rd)
   );

   cdoc_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_pixel_in),
      .rd_addr (col_ff),
      .rd_data (newer_rd)
   );

   assign req_ready = (state_ff == F_TAKE) && !queue_full;
   assign accept    = req_valid && req_ready;
   assign last_c    = (col_ff >= col_last);
   assign last_r    = (row_ff >= row_last);

   // Build the window: two stored columns and the column just arriving.
   always_comb begin
      cur[0] = older_rd;
      cur[1] = newer_rd;
      cur[2] = req_pixel_in;
      for (int k = 0; k < 3; k++) begin
         job.win[k][0] = wc_ff[k];
         job.win[k][1] = wc_ff[3 + k];
         job.win[k][2] = cur[k];
      end
      job.row_base = ROW_OUT_W'(row_ff) - ROW_OUT_W'(2);
      job.col_base = COL_OUT_W'(col_ff) - COL_OUT_W'(2);
      job.last_r   = last_r;
      job.last_c   = last_c;
   end

   assign push = accept && (row_ff >= RW'(2)) && (col_ff >= CW'(2));

   // F_READ lets the line-store read settle; F_TAKE then takes the pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_READ;
         col_ff   <= '0;
         row_ff   <= '0;
         wc_ff    <= '0;
      end else if (size_wr) begin
         state_ff <= F_READ;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         case (state_ff)
            F_READ: begin
               state_ff <= F_TAKE;
            end
            F_TAKE: begin
               if (accept) begin
                  state_ff <= F_READ;
                  for (int k = 0; k < 3; k++) begin
                     wc_ff[k]     <= wc_ff[3 + k];
                     wc_ff[3 + k] <= cur[k];
                  end
                  if (last_c) begin
                     col_ff <= '0;
                     row_ff <= last_r ? '0 : row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: begin
               state_ff <= F_READ;
            end
         endcase
      end
   end

endmodule

FILE: rtl/cdoc_back.sv
// Back end: for each queued window, runs the outputs it completes through a
// multiply-accumulate, a bit-serial divider and the offset clamp. Uses cdoc_pkg.
module cdoc_back (
   input  logic                           clock,
   input  logic                           reset,
   input  cdoc_pkg::cfg_type              cfg,
   input  logic                           queue_empty,
   input  cdoc_pkg::job_type              queue_job,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [cdoc_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [cdoc_pkg::ROW_OUT_W-1:0] rsp_out_row,
   output logic [cdoc_pkg::COL_OUT_W-1:0] rsp_out_col,
   output logic                           rsp_last_of_run,
   output logic                           rsp_frame_done
);

   import cdoc_pkg::*;

   localparam int CNT_W = $clog2(SUM_W);
   localparam int DM_W  = COEF_W + 1;

   typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_FIN, B_OUT} state_type;

   state_type               state_ff;
   job_type                 job_ff;
   logic [1:0]              di_ff, dj_ff, tr_ff, tc_ff;
   logic signed [SUM_W-1:0] acc_ff;
   logic [DM_W-1:0]         rem_ff;
   logic [SUM_W-1:0]        quo_ff;
   logic                    neg_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [PIX_W-1:0]        pix_ff;
   logic [ROW_OUT_W-1:0]    row_ff;
   logic [COL_OUT_W-1:0]    col_ff;
   logic                    last_ff, done_ff;

   logic [1:0]              di_max, dj_max;
   logic [2:0]              sr, sc;
   logic                    tap_on;
   logic [PIX_W-1:0]        tap_pix;
   logic [CSR_DAT_W-1:0]    coef_row;
   logic signed [COEF_W-1:0] coef;
   logic signed [PIX_W+COEF_W:0] prod;
   logic signed [SUM_W-1:0] acc_in;
   logic signed [DM_W-1:0]  div_sx;
   logic [DM_W-1:0]         dmag;
   logic [DM_W:0]           trial;
   logic signed [SUM_W-1:0] quot;
   logic signed [SUM_W:0]   biased;
   logic [PIX_W-1:0]        clamped;
   logic                    run_last;

   assign di_max   = job_ff.last_r ? 2'd2 : 2'd0;
   assign dj_max   = job_ff.last_c ? 2'd2 : 2'd0;
   assign run_last = (di_ff == di_max) && (dj_ff == dj_max);

   // One tap a cycle: taps that fall outside the frame count as zero.
   always_comb begin
      sr      = {1'b0, di_ff} + {1'b0, tr_ff};
      sc      = {1'b0, dj_ff} + {1'b0, tc_ff};
      tap_on  = (sr <= 3'd2) && (sc <= 3'd2);
      tap_pix = tap_on ? job_ff.win[sr[1:0]][sc[1:0]] : '0;
      case (tr_ff)
         2'd0:    coef_row = cfg.coef_top;
         2'd1:    coef_row = cfg.coef_mid;
         default: coef_row = cfg.coef_bottom;
      endcase
      case (tc_ff)
         2'd0:    coef = $signed(coef_row[15:0]);
         2'd1:    coef = $signed(coef_row[31:16]);
         default: coef = $signed(coef_row[47:32]);
      endcase
      prod   = $signed({1'b0, tap_pix}) * coef;
      acc_in = acc_ff + SUM_W'(prod);
   end

   // Divider step: magnitudes, one quotient bit a cycle.
   always_comb begin
      div_sx = DM_W'($signed(cfg.divisor));
      dmag   = div_sx[DM_W-1] ? DM_W'(-div_sx) : DM_W'(div_sx);
      trial  = {rem_ff, quo_ff[SUM_W-1]} - {1'b0, dmag};
   end

   // Sign, offset and clamp of the finished quotient.
   always_comb begin
      if (cfg.divisor == '0) begin
         quot = '0;
      end else if (neg_ff) begin
         quot = -$signed(quo_ff);
      end else begin
         quot = $signed(quo_ff);
      end
      biased = (SUM_W+1)'(quot) + (SUM_W+1)'($signed(cfg.offset));
      if (biased < 0) begin
         clamped = '0;
      end else if (biased > PIX_MAX) begin
         clamped = PIX_W'(PIX_MAX);
      end else begin
         clamped = biased[PIX_W-1:0];
      end
   end

   assign pop = (state_ff == B_IDLE) && !queue_empty;

   // Sequencer over the outputs of one window.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (!queue_empty) begin
                  job_ff   <= queue_job;
                  di_ff    <= '0;
                  dj_ff    <= '0;
                  tr_ff    <= '0;
                  tc_ff    <= '0;
                  acc_ff   <= '0;
                  state_ff <= B_MAC;
               end
            end
            B_MAC: begin
               acc_ff <= acc_in;
               if (tc_ff == 2'd2) begin
                  tc_ff <= '0;
                  tr_ff <= tr_ff + 1'b1;
                  if (tr_ff == 2'd2) begin
                     state_ff <= B_PREP;
                  end
               end else begin
                  tc_ff <= tc_ff + 1'b1;
               end
            end
            B_PREP: begin
               quo_ff   <= acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
               rem_ff   <= '0;
               neg_ff   <= acc_ff[SUM_W-1] ^ cfg.divisor[COEF_W-1];
               cnt_ff   <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               if (trial[DM_W]) begin
                  rem_ff <= {rem_ff[DM_W-2:0], quo_ff[SUM_W-1]};
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
               end else begin
                  rem_ff <= trial[DM_W-1:0];
                  quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
               end
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(SUM_W - 1)) begin
                  state_ff <= B_FIN;
               end
            end
            B_FIN: begin
               pix_ff   <= clamped;
               row_ff   <= job_ff.row_base + ROW_OUT_W'(di_ff);
               col_ff   <= job_ff.col_base + COL_OUT_W'(dj_ff);
               last_ff  <= run_last;
               done_ff  <= job_ff.last_r && job_ff.last_c &&
                           (di_ff == 2'd2) && (dj_ff == 2'd2);
               state_ff <= B_OUT;
            end
            B_OUT: begin
               if (rsp_ready) begin
                  if (run_last) begin
                     state_ff <= B_IDLE;
                  end else begin
                     if (dj_ff == dj_max) begin
                        dj_ff <= '0;
                        di_ff <= di_ff + 1'b1;
                     end else begin
                        dj_ff <= dj_ff + 1'b1;
                     end
                     tr_ff    <= '0;
                     tc_ff    <= '0;
                     acc_ff   <= '0;
                     state_ff <= B_MAC;
                  end
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = (state_ff == B_OUT);
   assign rsp_pixel_out   = pix_ff;
   assign rsp_out_row     = row_ff;
   assign rsp_out_col     = col_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_frame_done  = done_ff;

endmodule

FILE: rtl/conv3x3_divide_offset_clamp_unit.sv
// Top level of the 3x3 convolution unit with divide, offset and clamp.
// Holds the configuration registers; uses cdoc_pkg, cdoc_front, cdoc_fifo, cdoc_back.
//
// Usage:
//   Pixels of a grayscale frame enter in raster order on the req_ channel.
//   Filtered pixels leave on the rsp_ channel with their row and column. A
//   pixel in the last column or row can complete up to nine outputs, given in
//   row-major order; rsp_last_of_run marks the last of them. rsp_frame_done
//   marks the final output of the frame.
//   Registers are written on the csr_ channel, which is always ready; a
//   write of frame_width or frame_height restarts the frame.
//   The front alternates a read state, which covers the registered read of the
//   line-store RAMs, with a take state in which the pixel is taken. Each output
//   then passes in the back end through the multiply-accumulate over the nine
//   taps, a setup state, the bit-serial divider, a finish state and the
//   handoff; the back end starts the next output only after the handoff.
//   A two-entry window queue lets the front keep taking pixels while the
//   back works or the receiver stalls; a stalled result holds its fields.
//   Reset returns all registers to their defaults and the frame to its start;
//   the line stores need no clearing.
module conv3x3_divide_offset_clamp_unit #(
   parameter int MAX_WIDTH  = cdoc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cdoc_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cdoc_pkg::PIX_W-1:0]      req_pixel_in,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cdoc_pkg::PIX_W-1:0]      rsp_pixel_out,
   output logic [cdoc_pkg::ROW_OUT_W-1:0]  rsp_out_row,
   output logic [cdoc_pkg::COL_OUT_W-1:0]  rsp_out_col,
   output logic                            rsp_last_of_run,
   output logic                            rsp_frame_done,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cdoc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cdoc_pkg::CSR_DAT_W-1:0]  csr_data
);

   import cdoc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [10:0]   frame_width_ff;
   logic [12:0]   frame_height_ff;
   cfg_type       cfg_ff;
   logic          csr_wr;
   logic          size_wr;
   logic [CW-1:0] col_last;
   logic [RW-1:0] row_last;
   logic          push, pop, queue_full, queue_empty;
   job_type       push_job, pop_job;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign size_wr   = csr_wr && ((csr_index == CSR_FRAME_WIDTH) ||
                                 (csr_index == CSR_FRAME_HEIGHT));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff     <= RST_FRAME_WIDTH;
         frame_height_ff    <= RST_FRAME_HEIGHT;
         cfg_ff.coef_top    <= RST_COEF_TOP;
         cfg_ff.coef_mid    <= '0;
         cfg_ff.coef_bottom <= '0;
         cfg_ff.divisor     <= RST_DIVISOR;
         cfg_ff.offset      <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff     <= csr_data[10:0];
            CSR_FRAME_HEIGHT: frame_height_ff    <= csr_data[12:0];
            CSR_COEF_TOP:     cfg_ff.coef_top    <= csr_data;
            CSR_COEF_MID:     cfg_ff.coef_mid    <= csr_data;
            CSR_COEF_BOTTOM:  cfg_ff.coef_bottom <= csr_data;
            CSR_DIVISOR:      cfg_ff.divisor     <= csr_data[COEF_W-1:0];
            CSR_OFFSET:       cfg_ff.offset      <= csr_data[COEF_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Last column and row index after clamping the sizes to 3..MAX.
   always_comb begin
      if (frame_width_ff < 11'd3) begin
         col_last = CW'(2);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         col_last = CW'(MAX_WIDTH - 1);
      end else begin
         col_last = CW'(frame_width_ff - 11'd1);
      end
      if (frame_height_ff < 13'd3) begin
         row_last = RW'(2);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         row_last = RW'(MAX_HEIGHT - 1);
      end else begin
         row_last = RW'(frame_height_ff - 13'd1);
      end
   end

   cdoc_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_pixel_in (req_pixel_in),
      .size_wr      (size_wr),
      .col_last     (col_last),
      .row_last     (row_last),
      .queue_full   (queue_full),
      .push         (push),
      .job          (push_job)
   );

   cdoc_fifo #(.WIDTH($bits(job_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   cdoc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .queue_empty     (queue_empty),
      .queue_job       (pop_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_done  (rsp_frame_done)
   );

endmodule

FILE: rtl/cdoc_checker.sv
// Port-level checks of the 3x3 convolution unit, bound to its top level.
// Depends on cdoc_pkg and conv3x3_divide_offset_clamp_unit.
module cdoc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [cdoc_pkg::PIX_W-1:0]      req_pixel_in,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [cdoc_pkg::PIX_W-1:0]      rsp_pixel_out,
   input logic [cdoc_pkg::ROW_OUT_W-1:0]  rsp_out_row,
   input logic [cdoc_pkg::COL_OUT_W-1:0]  rsp_out_col,
   input logic                            rsp_last_of_run,
   input logic                            rsp_frame_done,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [cdoc_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [cdoc_pkg::CSR_DAT_W-1:0]  csr_data
);

   // A stalled result keeps its fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out) &&
         $stable(rsp_out_row) && $stable(rsp_out_col))
      else $error("stalled result changed");

   // The final output of a frame also ends its run.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_last_of_run)
      else $error("frame end without run end");

   // No result is offered right after reset.
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("result offered after reset");

   // Results need the arithmetic; one is never offered back to back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("results offered in consecutive cycles");

endmodule

bind conv3x3_divide_offset_clamp_unit cdoc_checker u_cdoc_checker (.*);
